// File: hdl/mtet_pkg.sv
`timescale 1ns / 1ps
package mtet_pkg;

    localparam int MODE_W           = 2;
    localparam int ANGLE_W          = 13;
    localparam int SPEED_W          = 16;
    localparam int CURRENT_W        = 16;
    localparam int PRESET_W         = 48;
    localparam int POS_W            = 31;
    localparam int DIST_W           = 48;
    localparam int INV_GEAR_W       = 17;
    localparam int DIST_PER_COUNT_W = 24;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 24;
    localparam int COUNT_W          = 3;

    localparam int DEF_COUNTS_PER_TURN = 8192;
    localparam int DEF_STARTUP_FRAMES  = 6;

    localparam logic [INV_GEAR_W-1:0]       INV_GEAR_RESET       = 17'h10000;
    localparam logic [DIST_PER_COUNT_W-1:0] DIST_PER_COUNT_RESET = 24'h010000;
    localparam logic [COUNT_W-1:0]          COUNT_MAX            = '1;

    localparam logic [MODE_W-1:0] MODE_FRAME    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET_POS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET_DIST = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_TRACK_EN       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_GEAR       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DIST_PER_COUNT = 2'd2;

    typedef enum logic [1:0] {
        OP_REPORT,
        OP_TRACK,
        OP_SET_POS,
        OP_SET_DIST
    } mtet_op_kind_t;

    // one classified item handed from the front end to the back end
    typedef struct packed {
        mtet_op_kind_t                op;
        logic                         clr;
        logic                         startup;
        logic signed [POS_W-1:0]      pos_inc;
        logic signed [DIST_W-1:0]     dist_inc;
        logic signed [PRESET_W-1:0]   preset;
        logic signed [SPEED_W-1:0]    speed;
        logic signed [CURRENT_W-1:0]  current;
    } mtet_op_t;

    typedef struct packed {
        logic signed [POS_W-1:0]      position;
        logic signed [DIST_W-1:0]     distance;
        logic signed [SPEED_W-1:0]    speed;
        logic signed [CURRENT_W-1:0]  current;
        logic                         startup;
    } mtet_res_t;

endpackage

// File: hdl/mtet_fifo.sv
`timescale 1ns / 1ps
module mtet_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hdl/mtet_front.sv
`timescale 1ns / 1ps
module mtet_front
    import mtet_pkg::*;
#(
    parameter int COUNTS_PER_TURN = DEF_COUNTS_PER_TURN,
    parameter int STARTUP_FRAMES  = DEF_STARTUP_FRAMES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        push,
    input  logic [MODE_W-1:0]           mode,
    input  logic [ANGLE_W-1:0]          angle_raw,
    input  logic signed [SPEED_W-1:0]   speed_rpm,
    input  logic signed [CURRENT_W-1:0] current_raw,
    input  logic signed [PRESET_W-1:0]  preset_value,
    input  logic                        q_full,
    output logic                        q_push,
    output mtet_op_t                    q_entry
);

    localparam int DW    = $clog2(COUNTS_PER_TURN + (1 << ANGLE_W)) + 1;
    localparam int CMP_W = $clog2(5 * COUNTS_PER_TURN + 6 * (1 << ANGLE_W)) + 1;
    localparam logic [CMP_W-1:0] LO_ZONE = CMP_W'(COUNTS_PER_TURN);
    localparam logic [CMP_W-1:0] HI_ZONE = CMP_W'(5 * COUNTS_PER_TURN);
    localparam logic signed [DW-1:0] TURN_D = DW'(COUNTS_PER_TURN);

    logic                        track_en_reg;
    logic [INV_GEAR_W-1:0]       inv_gear_reg;
    logic [DIST_PER_COUNT_W-1:0] dist_per_count_reg;
    logic [ANGLE_W-1:0]          prev_angle_reg, prev_angle_next;
    logic                        startup_flag_reg, startup_flag_next;
    logic [COUNT_W-1:0]          startup_count_reg, startup_count_next;

    logic                        accept;
    logic                        fire;
    logic [CMP_W-1:0]            now6, last6;
    logic signed [DW-1:0]        now_d, last_d, delta;
    logic signed [DW+17:0]       prod_pos;
    logic signed [DW+24:0]       prod_dist;

    assign cfg_ready = 1'b1;
    assign accept    = push && !q_full;
    assign q_push    = accept;

    // zone rule: top sixth versus bottom sixth of a turn means the angle wrapped
    always_comb
    begin
        now6   = CMP_W'(angle_raw) * CMP_W'(6);
        last6  = CMP_W'(prev_angle_reg) * CMP_W'(6);
        now_d  = DW'(angle_raw);
        last_d = DW'(prev_angle_reg);
        priority if (now6 > HI_ZONE && last6 < LO_ZONE)
        begin
            delta = now_d - last_d - TURN_D;
        end
        else if (now6 < LO_ZONE && last6 > HI_ZONE)
        begin
            delta = now_d - last_d + TURN_D;
        end
        else
        begin
            delta = now_d - last_d;
        end
        prod_pos  = (DW+18)'(delta) * (DW+18)'($signed({1'b0, inv_gear_reg}));
        prod_dist = (DW+25)'(delta) * (DW+25)'($signed({1'b0, dist_per_count_reg}));
    end

    always_comb
    begin
        prev_angle_next    = prev_angle_reg;
        startup_flag_next  = startup_flag_reg;
        startup_count_next = startup_count_reg;
        fire               = 1'b0;

        q_entry          = '0;
        q_entry.op       = OP_REPORT;
        q_entry.pos_inc  = POS_W'(prod_pos);
        q_entry.dist_inc = DIST_W'(prod_dist);
        q_entry.preset   = preset_value;

        unique case (mode)
            MODE_FRAME:
            begin
                q_entry.speed   = speed_rpm;
                q_entry.current = current_raw;
                if (track_en_reg)
                begin
                    q_entry.op      = OP_TRACK;
                    prev_angle_next = angle_raw;
                    if (startup_flag_reg)
                    begin
                        fire = (startup_count_reg >= COUNT_W'(STARTUP_FRAMES));
                        if (startup_count_reg != COUNT_MAX)
                        begin
                            startup_count_next = startup_count_reg + 1'b1;
                        end
                        if (fire)
                        begin
                            startup_flag_next = 1'b0;
                        end
                    end
                end
            end
            MODE_SET_POS:
            begin
                q_entry.op = OP_SET_POS;
            end
            MODE_SET_DIST:
            begin
                q_entry.op = OP_SET_DIST;
            end
            default:
            begin
                q_entry.op = OP_REPORT;
            end
        endcase

        q_entry.clr     = fire;
        q_entry.startup = startup_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_en_reg       <= 1'b1;
            inv_gear_reg       <= INV_GEAR_RESET;
            dist_per_count_reg <= DIST_PER_COUNT_RESET;
            prev_angle_reg     <= '0;
            startup_flag_reg   <= 1'b1;
            startup_count_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_TRACK_EN:       track_en_reg       <= cfg_data[0];
                    REG_INV_GEAR:       inv_gear_reg       <= cfg_data[INV_GEAR_W-1:0];
                    REG_DIST_PER_COUNT: dist_per_count_reg <= cfg_data;
                    default:            ;
                endcase
            end
            if (accept)
            begin
                prev_angle_reg    <= prev_angle_next;
                startup_flag_reg  <= startup_flag_next;
                startup_count_reg <= startup_count_next;
            end
        end
    end

endmodule

// File: hdl/mtet_back.sv
`timescale 1ns / 1ps
module mtet_back
    import mtet_pkg::*;
#(
    parameter int COUNTS_PER_TURN = DEF_COUNTS_PER_TURN
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  mtet_op_t  q_entry,
    output logic      q_pop,
    input  logic      out_full,
    output logic      out_push,
    output mtet_res_t out_res
);

    localparam int FOLD_RAW = $clog2(COUNTS_PER_TURN) + 18;
    localparam int FOLD_W   = (FOLD_RAW > POS_W) ? FOLD_RAW : POS_W;
    localparam logic signed [FOLD_W-1:0] HALF_F =
        FOLD_W'(longint'(COUNTS_PER_TURN) * 32768);
    localparam logic signed [FOLD_W-1:0] NEG_HALF_F = -HALF_F;
    localparam logic signed [POS_W-1:0] TURN_P =
        POS_W'(longint'(COUNTS_PER_TURN) * 65536);

    logic signed [POS_W-1:0]  pos_reg, pos_next;
    logic signed [DIST_W-1:0] dist_reg, dist_next;
    logic signed [POS_W-1:0]  pos_base, pos_fold;
    logic signed [DIST_W-1:0] dist_base;
    logic signed [FOLD_W-1:0] pos_ext;
    logic                     go;

    assign go       = !q_empty && !out_full;
    assign q_pop    = go;
    assign out_push = go;

    always_comb
    begin
        pos_base  = q_entry.clr ? '0 : pos_reg;
        dist_base = q_entry.clr ? '0 : dist_reg;
        pos_ext   = FOLD_W'(pos_base);
        // fold into one turn centered on zero before the delta goes in
        priority if (pos_ext >= HALF_F)
        begin
            pos_fold = pos_base - TURN_P;
        end
        else if (pos_ext < NEG_HALF_F)
        begin
            pos_fold = pos_base + TURN_P;
        end
        else
        begin
            pos_fold = pos_base;
        end

        pos_next  = pos_reg;
        dist_next = dist_reg;
        unique case (q_entry.op)
            OP_TRACK:
            begin
                pos_next  = pos_fold + q_entry.pos_inc;
                dist_next = dist_base + q_entry.dist_inc;
            end
            OP_SET_POS:
            begin
                pos_next = POS_W'(q_entry.preset);
            end
            OP_SET_DIST:
            begin
                dist_next = q_entry.preset;
            end
            OP_REPORT:
            begin
                pos_next = pos_reg;
            end
        endcase

        out_res.position = pos_next;
        out_res.distance = dist_next;
        out_res.speed    = q_entry.speed;
        out_res.current  = q_entry.current;
        out_res.startup  = q_entry.startup;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            dist_reg <= '0;
        end
        else if (go)
        begin
            pos_reg  <= pos_next;
            dist_reg <= dist_next;
        end
    end

    a_set_dist: assert property (@(posedge clk) disable iff (!rst_n)
        go && q_entry.op == OP_SET_DIST |=> dist_reg == $past(q_entry.preset))
        else $error("distance preset not taken");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(pos_reg) && $stable(dist_reg))
        else $error("accumulators moved without a transaction");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        go && q_entry.op == OP_TRACK && q_entry.clr
        |=> pos_reg == $past(q_entry.pos_inc) && dist_reg == $past(q_entry.dist_inc))
        else $error("startup clear did not restart accumulators");

endmodule

// File: hdl/multi_turn_encoder_tracker_core.sv
// path: an accepted transaction is registered in the op queue, then applied by the back-end update and
// registered in the result queue, which drives the result ports; a full result queue stalls the back end
// throughput: one item per cycle while the result queue is not full, set by the accumulate in the back end
// full rises only when the two-entry op queue backs up behind an unpopped result queue
// reset (rst_n low, asynchronous) empties both queues, zeroes position, distance and the
// last angle, arms the startup clear and restores the register defaults
`timescale 1ns / 1ps
module multi_turn_encoder_tracker_core
    import mtet_pkg::*;
#(
    parameter int COUNTS_PER_TURN = DEF_COUNTS_PER_TURN,
    parameter int STARTUP_FRAMES  = DEF_STARTUP_FRAMES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [MODE_W-1:0]           mode,
    input  logic [ANGLE_W-1:0]          angle_raw,
    input  logic signed [SPEED_W-1:0]   speed_rpm,
    input  logic signed [CURRENT_W-1:0] current_raw,
    input  logic signed [PRESET_W-1:0]  preset_value,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [POS_W-1:0]     position_q16,
    output logic signed [DIST_W-1:0]    distance_q16,
    output logic signed [SPEED_W-1:0]   speed_out,
    output logic signed [CURRENT_W-1:0] current_out,
    output logic                        startup_active
);

    logic      op_push, op_full, op_pop, op_empty;
    mtet_op_t  op_wr, op_rd;
    logic      res_push, res_full;
    mtet_res_t res_wr, res_rd;

    assign full = op_full;

    mtet_front #(
        .COUNTS_PER_TURN (COUNTS_PER_TURN),
        .STARTUP_FRAMES  (STARTUP_FRAMES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .mode         (mode),
        .angle_raw    (angle_raw),
        .speed_rpm    (speed_rpm),
        .current_raw  (current_raw),
        .preset_value (preset_value),
        .q_full       (op_full),
        .q_push       (op_push),
        .q_entry      (op_wr)
    );

    mtet_fifo #(
        .WIDTH ($bits(mtet_op_t)),
        .DEPTH (2)
    ) u_op_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .wdata (op_wr),
        .full  (op_full),
        .pop   (op_pop),
        .rdata (op_rd),
        .empty (op_empty)
    );

    mtet_back #(
        .COUNTS_PER_TURN (COUNTS_PER_TURN)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (op_empty),
        .q_entry  (op_rd),
        .q_pop    (op_pop),
        .out_full (res_full),
        .out_push (res_push),
        .out_res  (res_wr)
    );

    mtet_fifo #(
        .WIDTH ($bits(mtet_res_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wr),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rd),
        .empty (empty)
    );

    assign position_q16   = res_rd.position;
    assign distance_q16   = res_rd.distance;
    assign speed_out      = res_rd.speed;
    assign current_out    = res_rd.current;
    assign startup_active = res_rd.startup;

endmodule

// File: verif/tb_multi_turn_encoder_tracker_core.sv
`timescale 1ns / 1ps
module tb_multi_turn_encoder_tracker_core;
    import mtet_pkg::*;

    localparam longint COUNTS     = DEF_COUNTS_PER_TURN;
    localparam longint TURN_Q16   = COUNTS * 65536;
    localparam longint HALF_Q16   = TURN_Q16 / 2;
    localparam int     WARMUP     = DEF_STARTUP_FRAMES;
    localparam int     PHASE_LEN  = 210;
    localparam int     NUM_PHASES = 8;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [MODE_W-1:0]           mode;
        logic [ANGLE_W-1:0]          angle;
        logic signed [SPEED_W-1:0]   speed;
        logic signed [CURRENT_W-1:0] current;
        logic signed [PRESET_W-1:0]  preset;
    } frame_item_t;

    class tracker_scoreboard;
        bit                       track_en;
        longint                   inv_gear;
        longint                   dist_step;
        logic [ANGLE_W-1:0]       last_angle;
        logic signed [POS_W-1:0]  position;
        logic signed [DIST_W-1:0] distance;
        bit                       startup_flag;
        logic [COUNT_W-1:0]       startup_count;
        mtet_res_t                awaited_readings[$];
        int                       errors;
        int                       n_accepted;
        int                       n_checked;

        function new();
            track_en      = 1'b1;
            inv_gear      = 65536;
            dist_step     = 65536;
            last_angle    = '0;
            position      = '0;
            distance      = '0;
            startup_flag  = 1'b1;
            startup_count = '0;
            errors        = 0;
            n_accepted    = 0;
            n_checked     = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TRACK_EN:       track_en  = data[0];
                REG_INV_GEAR:       inv_gear  = longint'(data[INV_GEAR_W-1:0]);
                REG_DIST_PER_COUNT: dist_step = longint'(data[DIST_PER_COUNT_W-1:0]);
                default: ;
            endcase
        endfunction

        function void advance_angle(logic [ANGLE_W-1:0] angle);
            longint now_a;
            longint last_a;
            longint delta;
            longint pos;
            bit     fire;
            if (startup_flag) begin
                fire = (startup_count >= WARMUP);
                if (startup_count != COUNT_MAX)
                    startup_count = startup_count + 1'b1;
                if (fire) begin
                    position     = '0;
                    distance     = '0;
                    startup_flag = 1'b0;
                end
            end
            last_a     = longint'(last_angle);
            now_a      = longint'(angle);
            last_angle = angle;
            // zone rule: top sixth against bottom sixth means the angle wrapped through zero
            if (now_a * 6 > 5 * COUNTS && last_a * 6 < COUNTS)
                delta = -(COUNTS - now_a + last_a);
            else if (now_a * 6 < COUNTS && last_a * 6 > 5 * COUNTS)
                delta = now_a + (COUNTS - last_a);
            else
                delta = now_a - last_a;
            pos = position;
            if (pos >= HALF_Q16)
                pos -= TURN_Q16;
            else if (pos < -HALF_Q16)
                pos += TURN_Q16;
            pos      = pos + delta * inv_gear;
            position = pos[POS_W-1:0];
            distance = DIST_W'(longint'(distance) + delta * dist_step);
        endfunction

        function void predict_item(frame_item_t it);
            mtet_res_t r;
            r = '0;
            case (it.mode)
                MODE_FRAME: begin
                    r.speed   = it.speed;
                    r.current = it.current;
                    if (track_en)
                        advance_angle(it.angle);
                end
                MODE_SET_POS:  position = it.preset[POS_W-1:0];
                MODE_SET_DIST: distance = it.preset;
                default: ;
            endcase
            r.position = position;
            r.distance = distance;
            r.startup  = startup_flag;
            awaited_readings.push_back(r);
            n_accepted++;
        endfunction

        task report_mismatch(string what);
            if (errors < 40)
                $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(mtet_res_t got);
            mtet_res_t want;
            if (awaited_readings.size() == 0) begin
                report_mismatch("result transaction with nothing outstanding");
            end else begin
                want = awaited_readings.pop_front();
                n_checked++;
                if (got.position !== want.position)
                    report_mismatch($sformatf("result %0d position %0d, want %0d",
                                              n_checked, got.position, want.position));
                if (got.distance !== want.distance)
                    report_mismatch($sformatf("result %0d distance %0d, want %0d",
                                              n_checked, got.distance, want.distance));
                if (got.speed !== want.speed)
                    report_mismatch($sformatf("result %0d speed %0d, want %0d",
                                              n_checked, got.speed, want.speed));
                if (got.current !== want.current)
                    report_mismatch($sformatf("result %0d current %0d, want %0d",
                                              n_checked, got.current, want.current));
                if (got.startup !== want.startup)
                    report_mismatch($sformatf("result %0d startup %0b, want %0b",
                                              n_checked, got.startup, want.startup));
            end
        endtask

        function int pending();
            return awaited_readings.size();
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        push;
    logic                        full;
    logic [MODE_W-1:0]           mode;
    logic [ANGLE_W-1:0]          angle_raw;
    logic signed [SPEED_W-1:0]   speed_rpm;
    logic signed [CURRENT_W-1:0] current_raw;
    logic signed [PRESET_W-1:0]  preset_value;
    logic                        empty;
    logic                        pop;
    logic signed [POS_W-1:0]     position_q16;
    logic signed [DIST_W-1:0]    distance_q16;
    logic signed [SPEED_W-1:0]   speed_out;
    logic signed [CURRENT_W-1:0] current_out;
    logic                        startup_active;

    tracker_scoreboard sb;
    frame_item_t       stim_q[$];
    logic [ANGLE_W-1:0] last_sent_angle;
    int                 settings_done;

    multi_turn_encoder_tracker_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .mode           (mode),
        .angle_raw      (angle_raw),
        .speed_rpm      (speed_rpm),
        .current_raw    (current_raw),
        .preset_value   (preset_value),
        .empty          (empty),
        .pop            (pop),
        .position_q16   (position_q16),
        .distance_q16   (distance_q16),
        .speed_out      (speed_out),
        .current_out    (current_out),
        .startup_active (startup_active)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("FAILURE");
        $finish;
    end

    function automatic frame_item_t frame_item(int angle, int spd, int cur);
        frame_item_t it;
        it.mode    = MODE_FRAME;
        it.angle   = angle[ANGLE_W-1:0];
        it.speed   = spd[SPEED_W-1:0];
        it.current = cur[CURRENT_W-1:0];
        it.preset  = '0;
        return it;
    endfunction

    function automatic frame_item_t preset_item(logic [MODE_W-1:0] m, longint value);
        frame_item_t it;
        it.mode    = m;
        it.angle   = '0;
        it.speed   = '0;
        it.current = '0;
        it.preset  = value[PRESET_W-1:0];
        return it;
    endfunction

    function automatic frame_item_t random_item();
        frame_item_t   it;
        logic [63:0]   r;
        int            sel;
        int            t;
        longint        base;
        longint        fold_points[6];
        fold_points = '{HALF_Q16, HALF_Q16 - 1, -HALF_Q16, -HALF_Q16 - 1,
                        (64'sd1 <<< 30) - 1, -(64'sd1 <<< 30)};
        r          = {$urandom, $urandom};
        it.mode    = MODE_FRAME;
        it.angle   = ANGLE_W'($urandom_range(0, 8191));
        it.speed   = SPEED_W'($urandom);
        it.current = CURRENT_W'($urandom);
        it.preset  = r[PRESET_W-1:0];
        sel = $urandom_range(0, 99);
        if (sel < 72) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ;
                4, 5, 6: begin
                    t = int'(last_sent_angle) + int'($urandom_range(0, 400)) - 200;
                    t = (t + 8192) % 8192;
                    it.angle = t[ANGLE_W-1:0];
                end
                7, 8: begin
                    // jump across the zero crossing
                    if (last_sent_angle > 4096)
                        it.angle = ANGLE_W'($urandom_range(0, 1365));
                    else
                        it.angle = ANGLE_W'($urandom_range(6827, 8191));
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0: it.angle = 13'd1365;
                        1: it.angle = 13'd1366;
                        2: it.angle = 13'd6826;
                        3: it.angle = 13'd6827;
                        4: it.angle = 13'd0;
                        default: it.angle = 13'd8191;
                    endcase
                end
            endcase
            last_sent_angle = it.angle;
        end else if (sel < 82) begin
            it.mode = MODE_SET_POS;
            if ($urandom_range(0, 1)) begin
                base = fold_points[$urandom_range(0, 5)] + longint'($urandom_range(0, 4)) - 2;
                r = {$urandom, $urandom};
                it.preset = {r[PRESET_W-POS_W-1:0], base[POS_W-1:0]};
            end
        end else if (sel < 92) begin
            it.mode = MODE_SET_DIST;
            if ($urandom_range(0, 2) == 0) begin
                base = $urandom_range(0, 1) ? (64'sd1 <<< 47) - 1 - $urandom_range(0, 40000000)
                                            : -(64'sd1 <<< 47) + $urandom_range(0, 40000000);
                it.preset = base[PRESET_W-1:0];
            end
        end else begin
            it.mode = MODE_SPARE;
        end
        return it;
    endfunction

    task send_one(frame_item_t it);
        @(negedge clk);
        push         <= 1'b1;
        mode         <= it.mode;
        angle_raw    <= it.angle;
        speed_rpm    <= it.speed;
        current_raw  <= it.current;
        preset_value <= it.preset;
        do @(posedge clk); while (full);
        sb.predict_item(it);
    endtask

    task push_stim();
        int burst;
        int gap;
        while (stim_q.size() > 0) begin
            burst = $urandom_range(0, 3) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 12);
            while (burst > 0 && stim_q.size() > 0) begin
                send_one(stim_q.pop_front());
                burst--;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        push <= 1'b0;
    endtask

    task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task apply_setting(bit en, int gear, int step);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        // upper bits beyond each register's width carry noise
        write_reg(REG_TRACK_EN, {junk[CFG_DATA_W-1:1], en});
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_INV_GEAR, {junk[CFG_DATA_W-1:INV_GEAR_W], gear[INV_GEAR_W-1:0]});
        write_reg(REG_DIST_PER_COUNT, step[CFG_DATA_W-1:0]);
        settings_done++;
    endtask

    // receiver: pop pattern switches among always-ready, coin-flip and long stalls
    initial
    begin
        int  pop_style;
        int  style_left;
        int  hold_left;
        bit  hold_val;
        pop        = 1'b0;
        style_left = 0;
        hold_left  = 0;
        hold_val   = 1'b0;
        pop_style  = 0;
        forever begin
            @(negedge clk);
            if (style_left == 0) begin
                pop_style  = $urandom_range(0, 2);
                style_left = $urandom_range(50, 300);
            end
            style_left--;
            case (pop_style)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                default: begin
                    if (hold_left == 0) begin
                        hold_val  = !hold_val;
                        hold_left = hold_val ? $urandom_range(1, 10) : $urandom_range(5, 30);
                    end
                    hold_left--;
                    pop <= hold_val;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin : result_monitor
        mtet_res_t got;
        if (rst_n && pop && !empty) begin
            got.position = position_q16;
            got.distance = distance_q16;
            got.speed    = speed_out;
            got.current  = current_out;
            got.startup  = startup_active;
            sb.check_result(got);
        end
    end

    initial
    begin
        sb              = new();
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        push            = 1'b0;
        mode            = MODE_FRAME;
        angle_raw       = '0;
        speed_rpm       = '0;
        current_raw     = '0;
        preset_value    = '0;
        last_sent_angle = '0;
        settings_done   = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // frames with tracking off must not advance the warm-up count
        write_reg(REG_TRACK_EN, 24'h000000);
        stim_q.push_back(frame_item(3000, 32767, -32768));
        stim_q.push_back(frame_item(8191, -32768, 32767));
        push_stim();
        wait_idle();
        write_reg(REG_TRACK_EN, 24'hFFFFFF);

        stim_q.push_back(frame_item(0, 1, -1));
        stim_q.push_back(frame_item(8191, 100, 200));
        stim_q.push_back(frame_item(5, -100, -200));
        stim_q.push_back(preset_item(MODE_SET_POS, (64'sd1 <<< 47) - 1));
        stim_q.push_back(preset_item(MODE_SPARE, -1));
        stim_q.push_back(frame_item(1365, 0, 0));
        stim_q.push_back(frame_item(6827, 5, 6));
        stim_q.push_back(preset_item(MODE_SET_DIST, -(64'sd1 <<< 47)));
        stim_q.push_back(frame_item(1366, 7, 8));
        // warm-up clear lands on this frame
        stim_q.push_back(frame_item(6826, 9, 10));
        stim_q.push_back(frame_item(8191, 11, 12));
        stim_q.push_back(preset_item(MODE_SET_POS, HALF_Q16));
        stim_q.push_back(frame_item(8191, 0, 0));
        stim_q.push_back(preset_item(MODE_SET_POS, -HALF_Q16 - 1));
        stim_q.push_back(frame_item(8191, 0, 0));
        stim_q.push_back(preset_item(MODE_SET_POS, -HALF_Q16));
        stim_q.push_back(frame_item(8191, 0, 0));
        stim_q.push_back(preset_item(MODE_SET_POS, HALF_Q16 - 1));
        stim_q.push_back(frame_item(8191, 0, 0));
        stim_q.push_back(preset_item(MODE_SET_DIST, (64'sd1 <<< 47) - 1));
        stim_q.push_back(frame_item(0, 0, 0));
        stim_q.push_back(frame_item(8191, 0, 0));
        last_sent_angle = 13'd8191;
        push_stim();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: apply_setting(1'b1, 65536, 65536);
                1: apply_setting(1'b1, 131071, 24'hFFFFFF);
                2: apply_setting(1'b1, 0, 0);
                3: apply_setting(1'b0, 40000, 12345);
                4: apply_setting(1'b1, 1, 1);
                5: apply_setting(1'b1, $urandom_range(0, 131071), $urandom_range(0, 24'hFFFFFF));
                6: apply_setting(1'b1, 65536, $urandom_range(0, 24'hFFFFFF));
                default: apply_setting(1'b1, $urandom_range(1, 65536),
                                       $urandom_range(0, 24'hFFFFFF));
            endcase
            repeat (PHASE_LEN) stim_q.push_back(random_item());
            push_stim();
        end

        wait_idle();
        repeat (6) @(posedge clk);
        $display("checked %0d results against %0d accepted transactions", sb.n_checked,
                 sb.n_accepted);
        $display("covered warm-up clear, wrap crossings, presets and %0d register settings",
                 settings_done);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
